FILE: hw/rtl/kmaa_pkg.sv
package kmaa_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_POINT = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_COUNT = 2'd0,
		STAT_LSUM  = 2'd1,
		STAT_QSUM  = 2'd2,
		STAT_TOTAL = 2'd3
	} stat_t;

	localparam logic CFG_CLUSTERS = 1'b0;
	localparam logic CFG_DIMS     = 1'b1;

	localparam int COORD_W = 16;
	localparam int DIST_W  = 36;
	localparam int ACC_W   = 41;
	localparam int COUNT_W = 32;
	localparam int LSUM_W  = 40;
	localparam int QSUM_W  = 56;
	localparam int TOTAL_W = 48;
	localparam int ROOT_W  = 18;
	localparam int DATA_W  = 57;
	localparam int STAT_W  = LSUM_W + QSUM_W;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic clr;
		logic acc_clr;
		logic cnt_inc;
		logic rv_set;
		logic st_we;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/kmaa_ram.sv
module kmaa_ram #(
	parameter int W = 16,
	parameter int D = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/kmaa_sqrt.sv
module kmaa_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [kmaa_pkg::DIST_W-1:0]  value,
	output logic                         done,
	output logic [kmaa_pkg::ROOT_W-1:0]  root
);
	import kmaa_pkg::*;

	localparam int SW = DIST_W + 1;

	logic [DIST_W-1:0] v_q;
	logic [SW-1:0]     r_q;
	logic [SW-1:0]     bit_q;
	logic [4:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     trial;
	logic              ge;

	assign trial = r_q + bit_q;
	assign ge    = {1'b0, v_q} >= trial;
	assign done  = done_q;
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= SW'(1) << (DIST_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				v_q <= v_q - trial[DIST_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

FILE: hw/rtl/kmaa_cell.sv
module kmaa_cell #(
	parameter int IDX = 0,
	parameter int DIMS = 16,
	parameter int CW = 4
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  kmaa_pkg::cell_ctl_t                        ctl,
	input  logic                                       active,
	input  logic                                       cen_we,
	input  logic [((DIMS > 1) ? $clog2(DIMS) : 1)-1:0] cen_waddr,
	input  logic signed [kmaa_pkg::COORD_W-1:0]        cen_wdata,
	input  logic                                       v_in,
	input  logic [((DIMS > 1) ? $clog2(DIMS) : 1)-1:0] j_in,
	input  logic signed [kmaa_pkg::COORD_W-1:0]        x_in,
	output logic                                       v_out,
	output logic [((DIMS > 1) ? $clog2(DIMS) : 1)-1:0] j_out,
	output logic signed [kmaa_pkg::COORD_W-1:0]        x_out,
	input  logic                                       mv_in,
	input  logic [CW-1:0]                              bi_in,
	input  logic [kmaa_pkg::DIST_W-1:0]                bd_in,
	output logic                                       mv_out,
	output logic [CW-1:0]                              bi_out,
	output logic [kmaa_pkg::DIST_W-1:0]                bd_out,
	input  logic [((DIMS > 1) ? $clog2(DIMS) : 1)-1:0] st_raddr,
	input  logic [((DIMS > 1) ? $clog2(DIMS) : 1)-1:0] st_waddr,
	input  logic [kmaa_pkg::STAT_W-1:0]                st_wdata,
	output logic [kmaa_pkg::STAT_W-1:0]                st_rdata,
	output logic [kmaa_pkg::COUNT_W-1:0]               count,
	output logic                                       row_valid
);
	import kmaa_pkg::*;

	localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;

	logic                       v_s1;
	logic [DW-1:0]              j_s1;
	logic signed [COORD_W-1:0]  x_s1;
	logic signed [COORD_W-1:0]  cen_rd;
	logic signed [COORD_W:0]    diff;
	logic signed [2*COORD_W+1:0] prod;
	logic                       v_s2;
	logic [2*COORD_W-1:0]       sq_s2;
	logic [ACC_W-1:0]           acc_q;
	logic [DIST_W-1:0]          own;
	logic                       take;
	logic                       mv_q;
	logic [CW-1:0]              bi_q;
	logic [DIST_W-1:0]          bd_q;
	logic [COUNT_W-1:0]         count_q;
	logic                       rv_q;
	logic [STAT_W-1:0]          st_raw;

	kmaa_ram #(.W(COORD_W), .D(DIMS)) u_cen (
		.clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
		.raddr(j_in), .rdata(cen_rd)
	);

	kmaa_ram #(.W(STAT_W), .D(DIMS)) u_stat (
		.clk(clk), .we(ctl.st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_raw)
	);

	assign diff = {x_s1[COORD_W-1], x_s1} - {cen_rd[COORD_W-1], cen_rd};
	assign prod = diff * diff;
	assign own  = (acc_q > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_q[DIST_W-1:0];
	assign take = active && ((IDX == 0) || (own < bd_in));

	assign v_out     = v_s1;
	assign j_out     = j_s1;
	assign x_out     = x_s1;
	assign mv_out    = mv_q;
	assign bi_out    = bi_q;
	assign bd_out    = bd_q;
	assign st_rdata  = rv_q ? st_raw : '0;
	assign count     = count_q;
	assign row_valid = rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			mv_q    <= 1'b0;
			count_q <= '0;
			rv_q    <= 1'b0;
			acc_q   <= '0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			mv_q <= mv_in;
			if (ctl.acc_clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(sq_s2);
			end
			if (ctl.clr) begin
				count_q <= '0;
				rv_q    <= 1'b0;
			end else begin
				if (ctl.cnt_inc && (count_q != '1)) begin
					count_q <= count_q + COUNT_W'(1);
				end
				if (ctl.rv_set) begin
					rv_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		j_s1  <= j_in;
		x_s1  <= x_in;
		sq_s2 <= prod[2*COORD_W-1:0];
		bi_q  <= take ? CW'(IDX) : bi_in;
		bd_q  <= take ? own : bd_in;
	end
endmodule

FILE: hw/rtl/kmeans_assign_accumulate.sv
// Load, clear and non-final point beats are taken in S_IDLE and leave it
// ready; a read passes S_RDWT and S_DONE before its statistic is registered.
// A final point beat runs the coordinate feed through the cell chain, the
// minimum pass, the 18-step root and the statistic write-back; the first
// update of a cluster walks MAX_DIMS.
// Active-low asynchronous reset clears counts, total, row-valid flags, state.
module kmeans_assign_accumulate #(
	parameter int MAX_CLUSTERS = 16,
	parameter int MAX_DIMS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [4:0]                          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          command,
	input  logic [3:0]                          cluster_index,
	input  logic [3:0]                          dim_index,
	input  logic signed [kmaa_pkg::COORD_W-1:0] coord_value,
	input  logic                                point_last,
	input  logic [1:0]                          stat_kind,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                result_kind,
	output logic [3:0]                          closest_cluster,
	output logic [kmaa_pkg::DIST_W-1:0]         closest_sq_distance,
	output logic signed [kmaa_pkg::DATA_W-1:0]  read_data
);
	import kmaa_pkg::*;

	localparam int M   = MAX_CLUSTERS;
	localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW  = $clog2(MAX_CLUSTERS);
	localparam int DCW = $clog2(MAX_DIMS + 1);
	localparam int KCW = $clog2(MAX_CLUSTERS + 1);
	localparam int WTW = $clog2(MAX_CLUSTERS + 6);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FEED  = 8'b0000_0010,
		S_DRAIN = 8'b0000_0100,
		S_MINP  = 8'b0000_1000,
		S_ROOT  = 8'b0001_0000,
		S_UPDT  = 8'b0010_0000,
		S_RDWT  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [KCW-1:0]       k_q;
	logic [DCW-1:0]       d_q;
	logic [DCW-1:0]       jc_q;
	logic [DCW-1:0]       len_q;
	logic [WTW-1:0]       wt_q;
	logic                 inj_q;
	logic [CW-1:0]        best_q;
	logic [DIST_W-1:0]    bestd_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [CW-1:0]        rd_ci_q;
	logic                 rd_cok_q;
	logic                 rd_dok_q;
	logic [1:0]           rd_kind_q;
	logic                 res_kind_q;
	logic [3:0]           res_cl_q;
	logic [DIST_W-1:0]    res_dist_q;
	logic [DATA_W-1:0]    res_data_q;
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [3:0]           out_cl_q;
	logic [DIST_W-1:0]    out_dist_q;
	logic [DATA_W-1:0]    out_data_q;

	logic                 feed_v_s1;
	logic [DW-1:0]        feed_j_s1;
	logic                 up_v_s1;
	logic [DCW-1:0]       up_j_s1;
	logic                 up_v_s2;
	logic [DW-1:0]        up_j_s2;
	logic signed [COORD_W-1:0] up_x_s2;
	logic [2*COORD_W-1:0] up_sq_s2;
	logic signed [LSUM_W-1:0] up_l_s2;
	logic [QSUM_W-1:0]    up_q_s2;

	logic                 acc_in;
	logic                 ci_ok;
	logic                 di_ok;
	logic                 feed_issue;
	logic                 up_issue;
	logic                 up_end;
	logic                 sq_start;
	logic                 sq_done;
	logic [ROOT_W-1:0]    sq_root;
	logic [TOTAL_W:0]     total_sum;
	logic signed [COORD_W-1:0] pt_rd;
	logic signed [COORD_W-1:0] x_eff;
	logic signed [2*COORD_W-1:0] x_prod;
	logic [CW-1:0]        st_sel;
	logic [STAT_W-1:0]    st_cur;
	logic signed [LSUM_W:0] l_sum;
	logic signed [LSUM_W-1:0] l_new;
	logic [QSUM_W:0]      q_sum;
	logic [QSUM_W-1:0]    q_new;
	logic [DATA_W-1:0]    rd_val;
	logic [KCW-1:0]       k_eff;
	logic [DCW-1:0]       d_eff;

	logic                 cv [M+1];
	logic [DW-1:0]        cj [M+1];
	logic signed [COORD_W-1:0] cx [M+1];
	logic                 mv [M+1];
	logic [CW-1:0]        bi [M+1];
	logic [DIST_W-1:0]    bd [M+1];
	logic [STAT_W-1:0]    st_rd [M];
	logic [COUNT_W-1:0]   cnt [M];
	logic                 rv [M];
	cell_ctl_t            ctl [M];

	assign in_ready   = (state_q == S_IDLE);
	assign acc_in     = in_valid && in_ready;
	assign ci_ok      = (32'(cluster_index) < MAX_CLUSTERS);
	assign di_ok      = (32'(dim_index) < MAX_DIMS);
	assign feed_issue = (state_q == S_FEED) && (jc_q < d_q);
	assign up_issue   = (state_q == S_UPDT) && (jc_q < len_q);
	assign up_end     = (state_q == S_UPDT) && !up_issue && !up_v_s1 && !up_v_s2;
	assign sq_start   = (state_q == S_MINP) && mv[M];
	assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(sq_root);

	assign k_eff = (cfg_data == 5'd0) ? KCW'(1) :
		(32'(cfg_data) > MAX_CLUSTERS) ? KCW'(MAX_CLUSTERS) : KCW'(cfg_data);
	assign d_eff = (cfg_data == 5'd0) ? DCW'(1) :
		(32'(cfg_data) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(cfg_data);

	kmaa_ram #(.W(COORD_W), .D(MAX_DIMS)) u_point (
		.clk(clk),
		.we(acc_in && (command == CMD_POINT) && di_ok),
		.waddr(DW'(dim_index)),
		.wdata(coord_value),
		.raddr(jc_q[DW-1:0]),
		.rdata(pt_rd)
	);

	kmaa_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(bd[M]),
		.done(sq_done), .root(sq_root)
	);

	assign cv[0] = feed_v_s1;
	assign cj[0] = feed_j_s1;
	assign cx[0] = pt_rd;
	assign mv[0] = inj_q;
	assign bi[0] = '0;
	assign bd[0] = '0;

	assign x_eff  = (up_j_s1 < d_q) ? pt_rd : '0;
	assign x_prod = x_eff * x_eff;
	assign st_sel = (state_q == S_RDWT) ? rd_ci_q : best_q;
	assign st_cur = st_rd[st_sel];

	assign l_sum = {up_l_s2[LSUM_W-1], up_l_s2} + (LSUM_W + 1)'(up_x_s2);
	assign l_new = (l_sum[LSUM_W] != l_sum[LSUM_W-1]) ?
		{l_sum[LSUM_W], {(LSUM_W-1){~l_sum[LSUM_W]}}} : l_sum[LSUM_W-1:0];
	assign q_sum = {1'b0, up_q_s2} + (QSUM_W + 1)'(up_sq_s2);
	assign q_new = q_sum[QSUM_W] ? '1 : q_sum[QSUM_W-1:0];

	for (genvar c = 0; c < M; c++) begin : g_cell
		assign ctl[c].clr     = acc_in && (command == CMD_CLEAR);
		assign ctl[c].acc_clr = acc_in && (command == CMD_POINT) && point_last;
		assign ctl[c].cnt_inc = (state_q == S_ROOT) && sq_done && (best_q == CW'(c));
		assign ctl[c].rv_set  = up_end && (best_q == CW'(c));
		assign ctl[c].st_we   = up_v_s2 && (best_q == CW'(c));

		kmaa_cell #(.IDX(c), .DIMS(MAX_DIMS), .CW(CW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[c]),
			.active(KCW'(c) < k_q),
			.cen_we(acc_in && (command == CMD_LOAD) && ci_ok && di_ok &&
				(CW'(cluster_index) == CW'(c))),
			.cen_waddr(DW'(dim_index)),
			.cen_wdata(coord_value),
			.v_in(cv[c]), .j_in(cj[c]), .x_in(cx[c]),
			.v_out(cv[c+1]), .j_out(cj[c+1]), .x_out(cx[c+1]),
			.mv_in(mv[c]), .bi_in(bi[c]), .bd_in(bd[c]),
			.mv_out(mv[c+1]), .bi_out(bi[c+1]), .bd_out(bd[c+1]),
			.st_raddr((state_q == S_IDLE) ? DW'(dim_index) : jc_q[DW-1:0]),
			.st_waddr(up_j_s2),
			.st_wdata({l_new, q_new}),
			.st_rdata(st_rd[c]),
			.count(cnt[c]),
			.row_valid(rv[c])
		);
	end

	always_comb begin
		case (rd_kind_q)
			STAT_COUNT: rd_val = rd_cok_q ? DATA_W'(cnt[rd_ci_q]) : '0;
			STAT_LSUM:  rd_val = rd_dok_q ?
				{{(DATA_W-LSUM_W){st_cur[STAT_W-1]}}, st_cur[STAT_W-1:QSUM_W]} : '0;
			STAT_QSUM:  rd_val = rd_dok_q ? DATA_W'(st_cur[QSUM_W-1:0]) : '0;
			default:    rd_val = DATA_W'(total_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= KCW'((MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16);
			d_q         <= DCW'((MAX_DIMS < 16) ? MAX_DIMS : 16);
			jc_q        <= '0;
			wt_q        <= '0;
			inj_q       <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			feed_v_s1   <= 1'b0;
			up_v_s1     <= 1'b0;
			up_v_s2     <= 1'b0;
		end else begin
			feed_v_s1 <= feed_issue;
			up_v_s1   <= up_issue;
			up_v_s2   <= up_v_s1;
			if (cfg_we) begin
				if (cfg_index == CFG_CLUSTERS) begin
					k_q <= k_eff;
				end else begin
					d_q <= d_eff;
				end
			end
			if (out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						case (command)
							CMD_CLEAR: total_q <= '0;
							CMD_READ:  state_q <= S_RDWT;
							CMD_POINT: begin
								if (point_last) begin
									jc_q    <= '0;
									state_q <= S_FEED;
								end
							end
							default: ;
						endcase
					end
				end
				S_FEED: begin
					if (feed_issue) begin
						jc_q <= jc_q + DCW'(1);
					end else begin
						wt_q    <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					wt_q <= wt_q + WTW'(1);
					if (wt_q == WTW'(MAX_CLUSTERS + 4)) begin
						inj_q   <= 1'b1;
						state_q <= S_MINP;
					end
				end
				S_MINP: begin
					inj_q <= 1'b0;
					if (mv[M]) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
						jc_q    <= '0;
						state_q <= S_UPDT;
					end
				end
				S_UPDT: begin
					if (up_issue) begin
						jc_q <= jc_q + DCW'(1);
					end else if (up_end) begin
						state_q <= S_DONE;
					end
				end
				S_RDWT: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		feed_j_s1 <= jc_q[DW-1:0];
		up_j_s1   <= jc_q;
		up_j_s2   <= up_j_s1[DW-1:0];
		up_x_s2   <= x_eff;
		up_sq_s2  <= x_prod;
		up_l_s2   <= st_cur[STAT_W-1:QSUM_W];
		up_q_s2   <= st_cur[QSUM_W-1:0];
		if (acc_in) begin
			rd_ci_q   <= CW'(cluster_index);
			rd_cok_q  <= ci_ok;
			rd_dok_q  <= ci_ok && di_ok;
			rd_kind_q <= stat_kind;
		end
		if (sq_start) begin
			best_q  <= bi[M];
			bestd_q <= bd[M];
		end
		if ((state_q == S_ROOT) && sq_done) begin
			len_q <= rv[best_q] ? d_q : DCW'(MAX_DIMS);
		end
		if (up_end) begin
			res_kind_q <= 1'b0;
			res_cl_q   <= 4'(best_q);
			res_dist_q <= bestd_q;
			res_data_q <= '0;
		end else if (state_q == S_RDWT) begin
			res_kind_q <= 1'b1;
			res_cl_q   <= '0;
			res_dist_q <= '0;
			res_data_q <= rd_val;
		end
		if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
			out_kind_q <= res_kind_q;
			out_cl_q   <= res_cl_q;
			out_dist_q <= res_dist_q;
			out_data_q <= res_data_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign result_kind         = out_kind_q;
	assign closest_cluster     = out_cl_q;
	assign closest_sq_distance = out_dist_q;
	assign read_data           = out_data_q;
endmodule

FILE: hw/rtl/kmaa_checker.sv
module kmaa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [1:0]                          command,
	input logic                                point_last,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                result_kind,
	input logic [3:0]                          closest_cluster,
	input logic [kmaa_pkg::DIST_W-1:0]         closest_sq_distance,
	input logic signed [kmaa_pkg::DATA_W-1:0]  read_data
);
	import kmaa_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |-> read_data == '0)
		else $error("assignment beat carries read data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind |-> closest_cluster == '0 && closest_sq_distance == '0)
		else $error("read beat carries assignment fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_POINT) && point_last |=> !in_ready)
		else $error("input taken while a point is being assigned");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(closest_sq_distance))
		else $error("stalled output beat changed");
endmodule

bind kmeans_assign_accumulate kmaa_checker u_kmaa_checker (.*);

FILE: dv/tb.sv
module tb;
	import kmaa_pkg::*;

	localparam int NCL = 16;
	localparam int NDM = 16;
	localparam int SETTLE = 300;
	localparam int LIMIT = 1500000;

	typedef struct {
		cmd_t              cmd;
		logic [3:0]        ci;
		logic [3:0]        di;
		logic signed [15:0] val;
		logic              last;
		stat_t             kind;
	} beat_t;

	typedef struct {
		logic        kind;
		logic [3:0]  cl;
		logic [35:0] sqd;
		logic [56:0] data;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_CLUSTERS;
	logic [4:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = CMD_LOAD;
	logic [3:0] cluster_index = '0;
	logic [3:0] dim_index = '0;
	logic signed [15:0] coord_value = '0;
	logic point_last = 1'b0;
	logic [1:0] stat_kind = STAT_COUNT;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic [3:0] closest_cluster;
	logic [35:0] closest_sq_distance;
	logic signed [56:0] read_data;

	kmeans_assign_accumulate u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	beat_t beats_to_send[$];
	result_t results_due[$];
	beat_t beat_live;
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_cnt = 0;

	// predictor state
	logic signed [15:0] cent[NCL*NDM];
	logic signed [15:0] pbuf[NDM];
	longint unsigned cnt[NCL];
	longint lsum[NCL*NDM];
	longint unsigned qsum[NCL*NDM];
	longint unsigned total;
	int reg_k = 16;
	int reg_d = 16;

	// stimulus shadows
	logic signed [15:0] gen_cent[NCL*NDM];
	bit gen_pw[NDM];
	int gen_k = 16;
	int gen_d = 16;

	function automatic int eff_count(int r, int m);
		if (r == 0) return 1;
		if (r > m) return m;
		return r;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 18;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	task automatic clear_stats();
		foreach (cnt[i]) cnt[i] = 0;
		foreach (lsum[i]) begin
			lsum[i] = 0;
			qsum[i] = 0;
		end
		total = 0;
	endtask

	task automatic apply_beat(beat_t b);
		result_t r;
		int idx, k, d, best;
		longint unsigned cdist, best_dist, q;
		longint diff, s, x;
		idx = b.ci * NDM + b.di;
		r = '{kind: 1'b1, cl: '0, sqd: '0, data: '0};
		case (b.cmd)
			CMD_LOAD: cent[idx] = b.val;
			CMD_CLEAR: clear_stats();
			CMD_READ: begin
				case (b.kind)
					STAT_COUNT: r.data = 57'(cnt[b.ci]);
					STAT_LSUM: r.data = 57'(lsum[idx]);
					STAT_QSUM: r.data = 57'(qsum[idx]);
					default: r.data = 57'(total);
				endcase
				results_due.push_back(r);
			end
			default: begin
				pbuf[b.di] = b.val;
				if (b.last) begin
					k = eff_count(reg_k, NCL);
					d = eff_count(reg_d, NDM);
					best = 0;
					best_dist = 0;
					for (int c = 0; c < k; c++) begin
						cdist = 0;
						for (int j = 0; j < d; j++) begin
							diff = longint'(pbuf[j]) - longint'(cent[c*NDM+j]);
							cdist += diff * diff;
						end
						if (cdist > 64'hF_FFFF_FFFF) cdist = 64'hF_FFFF_FFFF;
						if (c == 0 || cdist < best_dist) begin
							best_dist = cdist;
							best = c;
						end
					end
					total += isqrt(best_dist);
					if (total > 64'hFFFF_FFFF_FFFF) total = 64'hFFFF_FFFF_FFFF;
					if (cnt[best] < 64'hFFFF_FFFF) cnt[best]++;
					for (int j = 0; j < d; j++) begin
						x = pbuf[j];
						s = lsum[best*NDM+j] + x;
						q = qsum[best*NDM+j] + longint'(x * x);
						if (s > 64'sd549755813887) s = 64'sd549755813887;
						if (s < -64'sd549755813888) s = -64'sd549755813888;
						if (q > 64'hFF_FFFF_FFFF_FFFF) q = 64'hFF_FFFF_FFFF_FFFF;
						lsum[best*NDM+j] = s;
						qsum[best*NDM+j] = q;
					end
					r.kind = 1'b0;
					r.cl = 4'(best);
					r.sqd = 36'(best_dist);
					results_due.push_back(r);
				end
			end
		endcase
	endtask

	task automatic flag_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) apply_beat(beat_live);
			if (!in_valid || in_ready) begin
				if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
					beat_live = beats_to_send.pop_front();
					in_valid <= 1'b1;
					command <= beat_live.cmd;
					cluster_index <= beat_live.ci;
					dim_index <= beat_live.di;
					coord_value <= beat_live.val;
					point_last <= beat_live.last;
					stat_kind <= beat_live.kind;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					flag_mismatch("unexpected beat", result_kind, 0);
				end else begin
					e = results_due.pop_front();
					if (result_kind !== e.kind) flag_mismatch("result_kind", result_kind, e.kind);
					if (closest_cluster !== e.cl)
						flag_mismatch("closest_cluster", closest_cluster, e.cl);
					if (closest_sq_distance !== e.sqd)
						flag_mismatch("closest_sq_distance", closest_sq_distance, e.sqd);
					if (read_data !== e.data) flag_mismatch("read_data", read_data, e.data);
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_cnt <= 3000;
				out_ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= recv_stall;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_beat(cmd_t c, int ci, int di, logic signed [15:0] v, bit last, int kind);
		beat_t b;
		b.cmd = c;
		b.ci = 4'(ci);
		b.di = 4'(di);
		b.val = v;
		b.last = last;
		b.kind = stat_t'(kind);
		beats_to_send.push_back(b);
		if (c == CMD_LOAD) gen_cent[ci*NDM+di] = v;
		if (c == CMD_POINT) gen_pw[di] = 1'b1;
	endtask

	task automatic send_point(int near, bit jitter);
		logic signed [15:0] v;
		for (int j = 0; j < gen_d; j++) begin
			if (near < 0) v = rand_coord();
			else if (jitter) v = 16'(gen_cent[near*NDM+j] + $signed($urandom_range(8)) - 4);
			else v = gen_cent[near*NDM+j];
			push_beat(CMD_POINT, $urandom_range(15) & 0, j, v, j == gen_d - 1,
				$urandom_range(3));
		end
	endtask

	task automatic wait_idle();
		while (beats_to_send.size() > 0 || in_valid || results_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(int k, int d);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLUSTERS;
		cfg_data <= 5'(k);
		@(posedge clk);
		reg_k = k;
		cfg_index <= CFG_DIMS;
		cfg_data <= 5'(d);
		@(posedge clk);
		reg_d = d;
		cfg_we <= 1'b0;
		gen_k = eff_count(k, NCL);
		gen_d = eff_count(d, NDM);
	endtask

	task automatic random_mix(int n);
		int sent, r, di;
		bit ok;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(99);
			if (r < 55) begin
				if ($urandom_range(2) == 0) send_point(-1, 1'b0);
				else send_point($urandom_range(gen_k - 1), $urandom_range(3) != 0);
				sent += gen_d;
			end else if (r < 67) begin
				push_beat(CMD_LOAD, $urandom_range(15), $urandom_range(15), rand_coord(),
					1'($urandom_range(1)), $urandom_range(3));
				sent++;
			end else if (r < 85) begin
				push_beat(CMD_READ, $urandom_range(15), $urandom_range(15), 16'($urandom),
					1'($urandom_range(1)), $urandom_range(3));
				sent++;
			end else if (r < 87) begin
				push_beat(CMD_CLEAR, $urandom_range(15), $urandom_range(15), 16'($urandom),
					1'($urandom_range(1)), $urandom_range(3));
				sent++;
			end else if (r < 95) begin
				repeat ($urandom_range(1, 3)) begin
					push_beat(CMD_POINT, $urandom_range(15), $urandom_range(15), rand_coord(),
						1'b0, $urandom_range(3));
					sent++;
				end
			end else begin
				di = $urandom_range(15);
				ok = 1'b1;
				for (int j = 0; j < gen_d; j++)
					if (!gen_pw[j] && j != di) ok = 1'b0;
				push_beat(CMD_POINT, $urandom_range(15), di, rand_coord(), ok,
					$urandom_range(3));
				sent++;
			end
		end
	endtask

	task automatic run_phase(int k, int d, int si, int rs, int n, bit hold);
		write_regs(k, d);
		send_idle = si;
		recv_stall = rs;
		if (hold) hold_req++;
		random_mix(n);
	endtask

	initial begin
		logic signed [15:0] v;
		clear_stats();
		foreach (gen_pw[j]) gen_pw[j] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// preload every centroid; cluster 1 mirrors cluster 0 so ties occur
		for (int c = 0; c < NCL; c++)
			for (int j = 0; j < NDM; j++) begin
				case (c)
					1: v = gen_cent[j];
					2: v = 16'sh7FFF;
					3: v = 16'sh8000;
					default: v = rand_coord();
				endcase
				push_beat(CMD_LOAD, c, j, v, 1'b0, STAT_COUNT);
			end
		for (int s = 0; s < 4; s++) push_beat(CMD_READ, 15, 15, 0, 1'b0, s);
		send_point(0, 1'b0);
		for (int s = 0; s < 4; s++) push_beat(CMD_READ, 0, 15, 0, 1'b1, s);
		push_beat(CMD_CLEAR, 0, 0, 0, 1'b1, STAT_TOTAL);
		push_beat(CMD_READ, 0, 0, 0, 1'b0, STAT_COUNT);
		push_beat(CMD_READ, 0, 0, 0, 1'b0, STAT_TOTAL);

		random_mix(40);
		run_phase(1, 1, 83, 0, 220, 1'b0);
		run_phase(31, 5, 0, 83, 260, 1'b0);
		run_phase(0, 0, 12, 12, 200, 1'b0);
		run_phase(7, 16, 0, 0, 300, 1'b1);
		run_phase(16, 3, 12, 12, 260, 1'b0);
		run_phase(17, 17, 0, 0, 250, 1'b0);
		run_phase(2, 9, 83, 83, 210, 1'b0);

		wait_idle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/kmaa_pkg.sv
hw/rtl/kmaa_ram.sv
hw/rtl/kmaa_sqrt.sv
hw/rtl/kmaa_cell.sv
hw/rtl/kmeans_assign_accumulate.sv
hw/rtl/kmaa_checker.sv
dv/tb.sv
